FILE: rtl/ufrd_pkg.sv
// ----------------------------------------------------------------------------
// ufrd_pkg
// Shared constants, types and codes of the uart frame receiver and dispatcher
// ----------------------------------------------------------------------------
package ufrd_pkg;

    localparam int FRAME_BYTES = 48;
    localparam int FRAME_AW    = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    localparam logic [7:0] START_BYTE  = 8'h2A;
    localparam logic [7:0] END_BYTE    = 8'h23;
    localparam logic [7:0] MIN_LEN     = 8'h02;

    localparam logic [7:0] CODE_REAL   = 8'h01;
    localparam logic [7:0] CODE_SOFT   = 8'h02;
    localparam logic [7:0] CODE_STAT_A = 8'h03;
    localparam logic [7:0] CODE_STAT_B = 8'h04;
    localparam logic [7:0] CODE_CMD_LO = 8'h10;
    localparam logic [7:0] CODE_CMD_HI = 8'h14;

    localparam logic [7:0] BODY_LONG   = 8'h04;
    localparam logic [7:0] BODY_SHORT  = 8'h03;

    localparam int REPLY_LONG_BYTES  = 7;
    localparam int REPLY_SHORT_BYTES = 6;
    localparam int REP_W             = $clog2(REPLY_LONG_BYTES);

    typedef enum logic [1:0] {
        CH_REAL  = 2'd0,
        CH_CMD   = 2'd1,
        CH_REPLY = 2'd2,
        CH_SOFT  = 2'd3
    } chan_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_RD_CODE,
        ST_RD_ARG,
        ST_DECIDE,
        ST_FWD_RD,
        ST_FWD_WR,
        ST_REPLY
    } disp_state_t;

    typedef struct packed {
        logic        done;
        logic [7:0]  len;
        logic [15:0] sum;
    } frame_info_t;

endpackage

FILE: rtl/ufrd_frame_ram.sv
// ----------------------------------------------------------------------------
// ufrd_frame_ram
// Simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ufrd_frame_ram #(
    parameter int DEPTH = 48,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ufrd_collector.sv
// ----------------------------------------------------------------------------
// ufrd_collector
// Start byte hunt, length capture, byte count and running checksum; writes
// each frame byte into the frame ram and flags a frame with a good end byte
// ----------------------------------------------------------------------------
module ufrd_collector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [7:0]                      rx_byte,
    output logic                            wr_en,
    output logic [ufrd_pkg::FRAME_AW-1:0]   wr_addr,
    output logic [7:0]                      wr_data,
    output ufrd_pkg::frame_info_t           frame_o
);

    localparam int AW = ufrd_pkg::FRAME_AW;
    localparam int CW = ufrd_pkg::CNT_W;

    logic [AW-1:0] count_reg, count_next;
    logic [7:0]    len_reg, len_next;
    logic [15:0]   sum_reg, sum_next;

    logic [CW-1:0] n;
    logic [7:0]    len_eff;
    logic [8:0]    total;

    always_comb begin
        n          = CW'(count_reg) + CW'(1);
        len_eff    = (count_reg == AW'(1)) ? rx_byte : len_reg;
        total      = {1'b0, len_eff} + 9'd3;
        count_next = count_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg;
        wr_data    = rx_byte;
        frame_o    = '0;
        if (accept) begin
            if (count_reg == '0) begin
                if (rx_byte == ufrd_pkg::START_BYTE) begin
                    wr_en      = 1'b1;
                    count_next = AW'(1);
                    sum_next   = '0;
                end
            end else begin
                wr_en    = 1'b1;
                len_next = len_eff;
                if (9'(n) <= {1'b0, len_eff}) begin
                    sum_next = sum_reg + 16'(rx_byte);
                end
                if (9'(n) < total) begin
                    count_next = (n >= CW'(ufrd_pkg::FRAME_BYTES)) ? '0 : AW'(n);
                end else begin
                    count_next   = '0;
                    frame_o.done = (9'(n) == total) && (rx_byte == ufrd_pkg::END_BYTE)
                                   && (len_eff >= ufrd_pkg::MIN_LEN);
                end
            end
        end
        frame_o.len = len_eff;
        frame_o.sum = sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            count_reg <= count_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

FILE: rtl/ufrd_dispatch.sv
// ----------------------------------------------------------------------------
// ufrd_dispatch
// Reads checksum, function code and argument of a finished frame back from
// the frame ram, then forwards the frame and/or builds the reply
// ----------------------------------------------------------------------------
module ufrd_dispatch (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ufrd_pkg::frame_info_t           frame_i,
    output logic                            in_ready,
    output logic                            rd_en,
    output logic [ufrd_pkg::FRAME_AW-1:0]   rd_addr,
    input  logic [7:0]                      rd_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    localparam int AW = ufrd_pkg::FRAME_AW;
    localparam int RW = ufrd_pkg::REP_W;

    localparam logic [RW-1:0] POS_START = RW'(0);
    localparam logic [RW-1:0] POS_BODY  = RW'(1);
    localparam logic [RW-1:0] POS_CODE  = RW'(2);
    localparam logic [RW-1:0] POS_ARG   = RW'(3);
    localparam logic [RW-1:0] POS_LO    = RW'(4);
    localparam logic [RW-1:0] POS_HI    = RW'(5);
    localparam logic [RW-1:0] POS_END   = RW'(6);

    ufrd_pkg::disp_state_t state_reg, state_next;

    logic [7:0]      len_reg, len_next;
    logic [15:0]     sum_reg, sum_next;
    logic [7:0]      lo_reg, lo_next;
    logic [7:0]      hi_reg, hi_next;
    logic [7:0]      code_reg, code_next;
    logic [7:0]      arg_reg, arg_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [RW-1:0]   rep_reg, rep_next;
    ufrd_pkg::chan_t chan_reg, chan_next;

    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    ufrd_pkg::chan_t out_chan_reg, out_chan_next;
    logic            out_last_reg, out_last_next;

    logic            out_free;
    logic            sum_ok;
    logic            fwd_last;
    logic            is_long;
    logic [RW-1:0]   rep_last;
    logic [RW-1:0]   rep_pos;
    logic [8:0]      rep_sum;
    logic [7:0]      rep_byte;
    logic            code_fwd;
    logic            code_reply;
    ufrd_pkg::chan_t code_chan;

    assign out_free = !out_valid_reg || m_tready;
    assign sum_ok   = ({hi_reg, lo_reg} == sum_reg);
    assign fwd_last = (idx_reg == AW'(len_reg + 8'd2));
    assign is_long  = (code_reg == ufrd_pkg::CODE_REAL);
    assign rep_last = is_long ? RW'(ufrd_pkg::REPLY_LONG_BYTES - 1)
                              : RW'(ufrd_pkg::REPLY_SHORT_BYTES - 1);
    assign rep_pos  = (is_long || rep_reg < POS_ARG) ? rep_reg : rep_reg + RW'(1);
    assign rep_sum  = is_long ? 9'(ufrd_pkg::BODY_LONG) + 9'(code_reg) + 9'(arg_reg)
                              : 9'(ufrd_pkg::BODY_SHORT) + 9'(code_reg);

    // function code decode
    always_comb begin
        code_fwd   = 1'b0;
        code_reply = 1'b0;
        code_chan  = ufrd_pkg::CH_REAL;
        case (code_reg) inside
            ufrd_pkg::CODE_REAL: begin
                code_fwd  = 1'b1;
                code_chan = ufrd_pkg::CH_REAL;
            end
            ufrd_pkg::CODE_SOFT: begin
                code_fwd  = 1'b1;
                code_chan = ufrd_pkg::CH_SOFT;
            end
            ufrd_pkg::CODE_STAT_A, ufrd_pkg::CODE_STAT_B: begin
                code_reply = 1'b1;
            end
            [ufrd_pkg::CODE_CMD_LO:ufrd_pkg::CODE_CMD_HI]: begin
                code_fwd  = 1'b1;
                code_chan = ufrd_pkg::CH_CMD;
            end
            default: begin
                code_fwd = 1'b0;
            end
        endcase
    end

    // reply byte by position
    always_comb begin
        case (rep_pos)
            POS_START: rep_byte = ufrd_pkg::START_BYTE;
            POS_BODY:  rep_byte = is_long ? ufrd_pkg::BODY_LONG : ufrd_pkg::BODY_SHORT;
            POS_CODE:  rep_byte = code_reg;
            POS_ARG:   rep_byte = arg_reg;
            POS_LO:    rep_byte = rep_sum[7:0];
            POS_HI:    rep_byte = {7'b0, rep_sum[8]};
            POS_END:   rep_byte = ufrd_pkg::END_BYTE;
            default:   rep_byte = ufrd_pkg::END_BYTE;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ufrd_pkg::ST_IDLE: begin
                if (frame_i.done) begin
                    state_next = ufrd_pkg::ST_RD_LO;
                end
            end
            ufrd_pkg::ST_RD_LO:   state_next = ufrd_pkg::ST_RD_HI;
            ufrd_pkg::ST_RD_HI:   state_next = ufrd_pkg::ST_RD_CODE;
            ufrd_pkg::ST_RD_CODE: state_next = ufrd_pkg::ST_RD_ARG;
            ufrd_pkg::ST_RD_ARG:  state_next = ufrd_pkg::ST_DECIDE;
            ufrd_pkg::ST_DECIDE: begin
                if (!sum_ok) begin
                    state_next = ufrd_pkg::ST_IDLE;
                end else if (code_fwd) begin
                    state_next = ufrd_pkg::ST_FWD_RD;
                end else if (code_reply) begin
                    state_next = ufrd_pkg::ST_REPLY;
                end else begin
                    state_next = ufrd_pkg::ST_IDLE;
                end
            end
            ufrd_pkg::ST_FWD_RD: state_next = ufrd_pkg::ST_FWD_WR;
            ufrd_pkg::ST_FWD_WR: begin
                if (out_free) begin
                    if (!fwd_last) begin
                        state_next = ufrd_pkg::ST_FWD_RD;
                    end else if (is_long) begin
                        state_next = ufrd_pkg::ST_REPLY;
                    end else begin
                        state_next = ufrd_pkg::ST_IDLE;
                    end
                end
            end
            ufrd_pkg::ST_REPLY: begin
                if (out_free && rep_reg == rep_last) begin
                    state_next = ufrd_pkg::ST_IDLE;
                end
            end
            default: state_next = ufrd_pkg::ST_IDLE;
        endcase
    end

    // ram reads, datapath and output register
    always_comb begin
        in_ready       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        code_next      = code_reg;
        arg_next       = arg_reg;
        idx_next       = idx_reg;
        rep_next       = rep_reg;
        chan_next      = chan_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_chan_next  = out_chan_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ufrd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                len_next = frame_i.len;
                sum_next = frame_i.sum;
            end
            ufrd_pkg::ST_RD_LO: begin
                rd_en   = 1'b1;
                rd_addr = AW'(len_reg);
            end
            ufrd_pkg::ST_RD_HI: begin
                rd_en   = 1'b1;
                rd_addr = AW'(len_reg + 8'd1);
                lo_next = rd_data;
            end
            ufrd_pkg::ST_RD_CODE: begin
                rd_en   = 1'b1;
                rd_addr = AW'(POS_CODE);
                hi_next = rd_data;
            end
            ufrd_pkg::ST_RD_ARG: begin
                rd_en     = 1'b1;
                rd_addr   = AW'(POS_ARG);
                code_next = rd_data;
            end
            ufrd_pkg::ST_DECIDE: begin
                arg_next  = rd_data;
                idx_next  = '0;
                rep_next  = '0;
                chan_next = code_chan;
            end
            ufrd_pkg::ST_FWD_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            ufrd_pkg::ST_FWD_WR: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data;
                    out_chan_next  = chan_reg;
                    out_last_next  = fwd_last;
                    idx_next       = idx_reg + AW'(1);
                end
            end
            ufrd_pkg::ST_REPLY: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rep_byte;
                    out_chan_next  = ufrd_pkg::CH_REPLY;
                    out_last_next  = (rep_reg == rep_last);
                    rep_next       = rep_reg + RW'(1);
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ufrd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        sum_reg      <= sum_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        code_reg     <= code_next;
        arg_reg      <= arg_next;
        idx_reg      <= idx_next;
        rep_reg      <= rep_next;
        chan_reg     <= chan_next;
        out_byte_reg <= out_byte_next;
        out_chan_reg <= out_chan_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_chan_reg;
    assign m_tlast  = out_last_reg;

    a_done_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_i.done |-> state_reg == ufrd_pkg::ST_IDLE)
        else $error("frame finished while dispatch busy");

    a_fwd_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ufrd_pkg::ST_FWD_WR) |->
        ($past(state_reg) == ufrd_pkg::ST_FWD_RD || $past(state_reg) == ufrd_pkg::ST_FWD_WR))
        else $error("forward load without ram read");

    a_fwd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ufrd_pkg::ST_FWD_RD) |-> (32'(idx_reg) < ufrd_pkg::FRAME_BYTES))
        else $error("forward index beyond frame store");

    a_reply_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ufrd_pkg::ST_REPLY && out_free && rep_reg == rep_last) |=>
        (out_valid_reg && out_last_reg && out_byte_reg == ufrd_pkg::END_BYTE))
        else $error("reply does not close with end byte");

endmodule

FILE: rtl/uart_frame_receiver_dispatch.sv
// ----------------------------------------------------------------------------
// uart_frame_receiver_dispatch
// Start/length/checksum/end deframer for received uart bytes with dispatch of
// good frames by function code to the real-data, command-response, uart
// reply and software-reply channels
// ----------------------------------------------------------------------------
// While collecting, one received byte is taken each cycle and written into a
// 48-byte frame ram. Once a frame closes with a good end byte the input is
// held off: states RD_LO to RD_ARG read checksum, function code and argument
// back from the ram, DECIDE checks and routes, a forwarded frame takes a ram
// read and an output load per byte and a reply an output load per byte, both
// waiting while the output side stalls. Frames dropped for a bad end byte, a
// short length or an overrun never hold the input off; a frame with a bad
// checksum or an unknown code still holds it off through the read and check
// states. The frame ram needs no clearing pass after reset.
module uart_frame_receiver_dispatch (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [1:0] m_tuser,   // channel
    output logic       m_tlast
);

    logic                          accept;
    logic                          wr_en;
    logic [ufrd_pkg::FRAME_AW-1:0] wr_addr;
    logic [7:0]                    wr_data;
    logic                          rd_en;
    logic [ufrd_pkg::FRAME_AW-1:0] rd_addr;
    logic [7:0]                    rd_data;
    ufrd_pkg::frame_info_t         frame;

    assign accept = s_tvalid && s_tready;

    ufrd_collector u_collector (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_tdata),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .frame_o (frame)
    );

    ufrd_frame_ram #(
        .DEPTH (ufrd_pkg::FRAME_BYTES),
        .WIDTH (8)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ufrd_dispatch u_dispatch (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .frame_i  (frame),
        .in_ready (s_tready),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
